/* rtl/rss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the rotate and scale pixel sampler.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int SRC_DIM_DEF   = 128;
	localparam int FRAC_BITS_DEF = 4;

	// Configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 18;

	typedef enum logic [CFG_IW-1:0] {
		REG_COS_ANGLE     = 3'd0,
		REG_SIN_ANGLE     = 3'd1,
		REG_DEST_CENTER_X = 3'd2,
		REG_DEST_CENTER_Y = 3'd3,
		REG_INV_SCALE_X   = 3'd4,
		REG_INV_SCALE_Y   = 3'd5,
		REG_SOURCE_WIDTH  = 3'd6,
		REG_SOURCE_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam logic signed [15:0] COS_RST   = 16'sd16384;
	localparam logic signed [15:0] SIN_RST   = 16'sd0;
	localparam logic signed [17:0] CENTER_RST = 18'sd0;
	localparam logic signed [16:0] SCALE_RST = 17'sd256;
	localparam logic [7:0]         EXTENT_RST = 8'd1;

	// Input mode codes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Fraction bits of angle and inverse scale
	localparam int ANGLE_FRAC = 14;
	localparam int SCALE_FRAC = 8;

	// Alpha byte position in ARGB
	localparam int ALPHA_LSB = 24;

endpackage

/* rtl/rotate_scale_pixel_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_scale_pixel_sampler
// Inverse-mapped rotate and scale with nearest-neighbor lookup into a
// source pixel store. Load items fill the store, sample items return colors.
// ----------------------------------------------------------------------------
// Each input transfer passes through stages 1 to 7 before its result is output.
// Throughput: one item per cycle while the output is not stalled; seven
// pipeline stages, each with its own valid bit, so bubbles close up in a stall.
// The store is one read/write port, accessed between stages 5 and 6 in item order.
// Reset: clears all valid bits and loads register defaults; the pixel store
// is not cleared and holds garbage until written.
module rotate_scale_pixel_sampler #(
	parameter int SRC_DIM   = rss_pkg::SRC_DIM_DEF,
	parameter int FRAC_BITS = rss_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rss_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rss_pkg::CFG_DW-1:0] cfg_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic signed [12:0]         pos_x,
	input  logic signed [12:0]         pos_y,
	input  logic [31:0]                pixel_color,
	// results
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                sample_color,
	output logic                       sample_visible
);

	localparam int AW        = $clog2(SRC_DIM);
	localparam int MEM_DEPTH = 1 << (2 * AW);
	localparam int HALF_PIX  = 1 << (FRAC_BITS - 1);
	// offset from center
	localparam int DW  = ((13 + FRAC_BITS > 18) ? 13 + FRAC_BITS : 18) + 1;
	// rotation product and sum
	localparam int PW  = 16 + DW;
	localparam int LW  = PW + 1;
	// scale multiply split into low and high partial products
	localparam int LO_BITS = 18;
	localparam int LO_W    = LO_BITS + 1 + 17;
	localparam int HI_W    = LW - LO_BITS + 17;
	localparam int UW      = LW + 17;
	localparam int TW      = UW + 1;
	// fraction bits of the scaled coordinate
	localparam int S       = rss_pkg::ANGLE_FRAC + rss_pkg::SCALE_FRAC + FRAC_BITS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [15:0] cos_q, sin_q;
	logic signed [17:0] dcx_q, dcy_q;
	logic signed [16:0] isx_q, isy_q;
	logic [7:0]         src_w_q, src_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q   <= rss_pkg::COS_RST;
			sin_q   <= rss_pkg::SIN_RST;
			dcx_q   <= rss_pkg::CENTER_RST;
			dcy_q   <= rss_pkg::CENTER_RST;
			isx_q   <= rss_pkg::SCALE_RST;
			isy_q   <= rss_pkg::SCALE_RST;
			src_w_q <= rss_pkg::EXTENT_RST;
			src_h_q <= rss_pkg::EXTENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (rss_pkg::cfg_reg_t'(cfg_index))
				rss_pkg::REG_COS_ANGLE:     cos_q   <= cfg_data[15:0];
				rss_pkg::REG_SIN_ANGLE:     sin_q   <= cfg_data[15:0];
				rss_pkg::REG_DEST_CENTER_X: dcx_q   <= cfg_data[17:0];
				rss_pkg::REG_DEST_CENTER_Y: dcy_q   <= cfg_data[17:0];
				rss_pkg::REG_INV_SCALE_X:   isx_q   <= cfg_data[16:0];
				rss_pkg::REG_INV_SCALE_Y:   isy_q   <= cfg_data[16:0];
				rss_pkg::REG_SOURCE_WIDTH:  src_w_q <= cfg_data[7:0];
				rss_pkg::REG_SOURCE_HEIGHT: src_h_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage valids and advance enables
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// a stage loads when it is empty or its contents move on
	assign en_s7 = !v_s7 || out_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_ready  = en_s1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: offset pixel center from destination center, decode load
	// ------------------------------------------------------------------
	logic signed [DW-1:0] dx_in, dy_in;
	logic                 ld_ok_in;

	assign dx_in = (DW'(pos_x) <<< FRAC_BITS) + DW'(HALF_PIX) - DW'(dcx_q);
	assign dy_in = (DW'(pos_y) <<< FRAC_BITS) + DW'(HALF_PIX) - DW'(dcy_q);
	assign ld_ok_in = !pos_x[12] && !pos_y[12]
		&& ($unsigned(pos_x) < 13'(SRC_DIM)) && ($unsigned(pos_y) < 13'(SRC_DIM));

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic                 mode_s1, ld_ok_s1;
	logic [2*AW-1:0]      ld_addr_s1;
	logic [31:0]          color_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1      <= dx_in;
			dy_s1      <= dy_in;
			mode_s1    <= mode;
			ld_ok_s1   <= ld_ok_in;
			ld_addr_s1 <= {AW'(pos_y), AW'(pos_x)};
			color_s1   <= pixel_color;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: rotation products
	// ------------------------------------------------------------------
	logic signed [PW-1:0] p_cx_s2, p_sy_s2, p_cy_s2, p_sx_s2;
	logic                 mode_s2, ld_ok_s2;
	logic [2*AW-1:0]      ld_addr_s2;
	logic [31:0]          color_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_cx_s2    <= PW'(cos_q) * PW'(dx_s1);
			p_sy_s2    <= PW'(sin_q) * PW'(dy_s1);
			p_cy_s2    <= PW'(cos_q) * PW'(dy_s1);
			p_sx_s2    <= PW'(sin_q) * PW'(dx_s1);
			mode_s2    <= mode_s1;
			ld_ok_s2   <= ld_ok_s1;
			ld_addr_s2 <= ld_addr_s1;
			color_s2   <= color_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: rotated local coordinates
	// ------------------------------------------------------------------
	logic signed [LW-1:0] lx_s3, ly_s3;
	logic                 mode_s3, ld_ok_s3;
	logic [2*AW-1:0]      ld_addr_s3;
	logic [31:0]          color_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			lx_s3      <= LW'(p_cx_s2) + LW'(p_sy_s2);
			ly_s3      <= LW'(p_cy_s2) - LW'(p_sx_s2);
			mode_s3    <= mode_s2;
			ld_ok_s3   <= ld_ok_s2;
			ld_addr_s3 <= ld_addr_s2;
			color_s3   <= color_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: scale partial products (low unsigned slice, high signed slice)
	// ------------------------------------------------------------------
	logic signed [LO_BITS:0]       lx_lo, ly_lo;
	logic signed [LW-LO_BITS-1:0]  lx_hi, ly_hi;

	assign lx_lo = $signed({1'b0, lx_s3[LO_BITS-1:0]});
	assign ly_lo = $signed({1'b0, ly_s3[LO_BITS-1:0]});
	assign lx_hi = $signed(lx_s3[LW-1:LO_BITS]);
	assign ly_hi = $signed(ly_s3[LW-1:LO_BITS]);

	logic signed [LO_W-1:0] ux_lo_s4, uy_lo_s4;
	logic signed [HI_W-1:0] ux_hi_s4, uy_hi_s4;
	logic                   mode_s4, ld_ok_s4;
	logic [2*AW-1:0]        ld_addr_s4;
	logic [31:0]            color_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ux_lo_s4   <= LO_W'(lx_lo) * LO_W'(isx_q);
			uy_lo_s4   <= LO_W'(ly_lo) * LO_W'(isy_q);
			ux_hi_s4   <= HI_W'(lx_hi) * HI_W'(isx_q);
			uy_hi_s4   <= HI_W'(ly_hi) * HI_W'(isy_q);
			mode_s4    <= mode_s3;
			ld_ok_s4   <= ld_ok_s3;
			ld_addr_s4 <= ld_addr_s3;
			color_s4   <= color_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: recombine, shift by half extent, range test, floor to index
	// ------------------------------------------------------------------
	logic signed [TW-1:0] half_x, half_y, tx, ty;
	logic [7:0]           idx_x, idx_y;
	logic                 ok_x, ok_y;

	assign half_x = TW'(src_w_q) <<< (S - 1);
	assign half_y = TW'(src_h_q) <<< (S - 1);
	assign tx = (TW'(ux_hi_s4) <<< LO_BITS) + TW'(ux_lo_s4) + half_x;
	assign ty = (TW'(uy_hi_s4) <<< LO_BITS) + TW'(uy_lo_s4) + half_y;
	assign idx_x = tx[S+7:S];
	assign idx_y = ty[S+7:S];
	// negative or too large values show up in the bits above the index byte
	assign ok_x = (tx[TW-1:S+8] == '0) && (idx_x < src_w_q) && (32'(idx_x) < SRC_DIM);
	assign ok_y = (ty[TW-1:S+8] == '0) && (idx_y < src_h_q) && (32'(idx_y) < SRC_DIM);

	logic            mode_s5, hit_s5;
	logic [2*AW-1:0] addr_s5;
	logic [31:0]     color_s5;
	logic [7:0]      idx_x_s5, idx_y_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			mode_s5  <= mode_s4;
			hit_s5   <= (mode_s4 == rss_pkg::MODE_SAMPLE) ? (ok_x && ok_y) : ld_ok_s4;
			addr_s5  <= (mode_s4 == rss_pkg::MODE_SAMPLE) ?
				{AW'(idx_y), AW'(idx_x)} : ld_addr_s4;
			color_s5 <= color_s4;
			idx_x_s5 <= idx_x;
			idx_y_s5 <= idx_y;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: pixel store access, one item at a time in order
	// ------------------------------------------------------------------
	logic [31:0] src_mem [MEM_DEPTH];
	logic [31:0] rdata_s6;
	logic        mode_s6, hit_s6;
	logic        mem_we, mem_re;

	assign mem_we = v_s5 && en_s6 && (mode_s5 == rss_pkg::MODE_LOAD) && hit_s5;
	assign mem_re = v_s5 && en_s6 && (mode_s5 == rss_pkg::MODE_SAMPLE);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			src_mem[addr_s5] <= color_s5;
		end
		if (mem_re) begin
			rdata_s6 <= src_mem[addr_s5];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			mode_s6 <= mode_s5;
			hit_s6  <= hit_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: output register, drop transparent colors
	// ------------------------------------------------------------------
	logic        show_s6;
	logic [31:0] color_s7;
	logic        visible_s7;

	assign show_s6 = (mode_s6 == rss_pkg::MODE_SAMPLE) && hit_s6
		&& (rdata_s6[31:rss_pkg::ALPHA_LSB] != '0);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			color_s7   <= show_s6 ? rdata_s6 : '0;
			visible_s7 <= show_s6;
		end
	end

	assign sample_color   = color_s7;
	assign sample_visible = visible_s7;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_visible_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_visible |-> sample_color[31:rss_pkg::ALPHA_LSB] != '0)
		else $error("visible result with zero alpha");

	a_index_in_extent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && mode_s5 == rss_pkg::MODE_SAMPLE && hit_s5
			|-> idx_x_s5 < src_w_q && idx_y_s5 < src_h_q)
		else $error("sample index beyond source extent");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en_s6 |=> v_s5 && $stable(addr_s5) && $stable(mode_s5))
		else $error("stalled stage 5 item lost or changed");

endmodule

/* tb/sv/rss_sampler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_sampler_checker
// Watches the register, input and result channels of the rotate and scale
// sampler, keeps its own register set and pixel store, predicts the color of
// every accepted item and compares each result transfer in order.
// ----------------------------------------------------------------------------
module rss_sampler_checker
	import rss_pkg::*;
#(
	parameter int SRC_DIM   = SRC_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                mode,
	input  logic signed [12:0]  pos_x,
	input  logic signed [12:0]  pos_y,
	input  logic [31:0]         pixel_color,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [31:0]         sample_color,
	input  logic                sample_visible,
	output int                  fail_count,
	output int                  in_flight,
	output int                  checked_count,
	output int                  sample_count,
	output int                  lit_count
);

	typedef struct packed {
		logic [31:0] color;
		logic        visible;
	} drawn_px_t;

	localparam longint ONE_PX  = longint'(1) << FRAC_BITS;
	localparam longint HALF_PX = longint'(1) << (FRAC_BITS - 1);
	// fraction bits of the scaled local coordinate
	localparam int UV_FRAC = ANGLE_FRAC + SCALE_FRAC + FRAC_BITS;

	logic signed [15:0] cos_r, sin_r;
	logic signed [17:0] cx_r, cy_r;
	logic signed [16:0] isx_r, isy_r;
	logic [7:0]         w_r, h_r;
	logic [31:0]        src_store [SRC_DIM*SRC_DIM];
	drawn_px_t          drawn_q [$];

	initial begin
		fail_count    = 0;
		in_flight     = 0;
		checked_count = 0;
		sample_count  = 0;
		lit_count     = 0;
	end

	// source index on one axis, -1 when past the half extent
	function automatic longint axis_pick(longint u, longint ext);
		longint half;
		half = ext <<< (UV_FRAC - 1);
		if (u < -half || u > half)
			return -1;
		return (u + half) >>> UV_FRAC;
	endfunction

	function automatic drawn_px_t sample_lookup(logic m, logic signed [12:0] x,
			logic signed [12:0] y);
		drawn_px_t   r;
		longint      dx, dy, lx, ly, ix, iy;
		logic [31:0] c;
		r.color   = '0;
		r.visible = 1'b0;
		if (m == MODE_LOAD)
			return r;
		dx = longint'(x) * ONE_PX + HALF_PX - longint'(cx_r);
		dy = longint'(y) * ONE_PX + HALF_PX - longint'(cy_r);
		lx = longint'(cos_r) * dx + longint'(sin_r) * dy;
		ly = longint'(cos_r) * dy - longint'(sin_r) * dx;
		ix = axis_pick(lx * longint'(isx_r), longint'(w_r));
		iy = axis_pick(ly * longint'(isy_r), longint'(h_r));
		if (ix < 0 || iy < 0 || ix >= longint'(w_r) || iy >= longint'(h_r)
				|| ix >= SRC_DIM || iy >= SRC_DIM)
			return r;
		c = src_store[iy * SRC_DIM + ix];
		if (c[ALPHA_LSB +: 8] == 8'h00)
			return r;
		r.color   = c;
		r.visible = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drawn_px_t want;
		if (!arst_n) begin
			cos_r = COS_RST;
			sin_r = SIN_RST;
			cx_r  = CENTER_RST;
			cy_r  = CENTER_RST;
			isx_r = SCALE_RST;
			isy_r = SCALE_RST;
			w_r   = EXTENT_RST;
			h_r   = EXTENT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COS_ANGLE:     cos_r = cfg_data[15:0];
					REG_SIN_ANGLE:     sin_r = cfg_data[15:0];
					REG_DEST_CENTER_X: cx_r  = cfg_data[17:0];
					REG_DEST_CENTER_Y: cy_r  = cfg_data[17:0];
					REG_INV_SCALE_X:   isx_r = cfg_data[16:0];
					REG_INV_SCALE_Y:   isy_r = cfg_data[16:0];
					REG_SOURCE_WIDTH:  w_r   = cfg_data[7:0];
					REG_SOURCE_HEIGHT: h_r   = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				// predict before the store takes this transfer's write
				drawn_q.push_back(sample_lookup(mode, pos_x, pos_y));
				in_flight++;
				if (mode == MODE_SAMPLE)
					sample_count++;
				else if (pos_x >= 0 && pos_x < SRC_DIM && pos_y >= 0 && pos_y < SRC_DIM)
					src_store[int'(pos_y) * SRC_DIM + int'(pos_x)] = pixel_color;
			end
			if (out_valid && out_ready) begin
				if (drawn_q.size() == 0) begin
					$display("%0t checker: result with nothing expected, got color %08h visible %0b",
						$time, sample_color, sample_visible);
					fail_count++;
				end else begin
					want = drawn_q.pop_front();
					in_flight--;
					checked_count++;
					if (want.visible)
						lit_count++;
					if (sample_color !== want.color) begin
						$display("%0t checker: sample_color expected %08h got %08h",
							$time, want.color, sample_color);
						fail_count++;
					end
					if (sample_visible !== want.visible) begin
						$display("%0t checker: sample_visible expected %0b got %0b",
							$time, want.visible, sample_visible);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* tb/sv/rotate_scale_pixel_sampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_scale_pixel_sampler_tb
// Drives register writes, source pixel loads and destination samples into the
// sampler with random gaps and output stalls; the checker beside it predicts
// and compares every result. Directed corner items come first, then a corner
// block of the store and the last two columns beside it are filled, and a
// sweep of register settings runs traffic whose reads stay on filled entries.
// ----------------------------------------------------------------------------
module rotate_scale_pixel_sampler_tb;
	import rss_pkg::*;

	localparam int SRC_DIM      = SRC_DIM_DEF;
	localparam int FILL_DIM     = 16;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 40;
	localparam int CLAMP_PHASE  = 6;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic signed [15:0] cos_a;
		logic signed [15:0] sin_a;
		logic signed [17:0] cx;
		logic signed [17:0] cy;
		logic signed [16:0] isx;
		logic signed [16:0] isy;
		logic [7:0]         w;
		logic [7:0]         h;
	} setting_t;

	localparam setting_t BOOT_SETTING = '{cos_a: COS_RST, sin_a: SIN_RST,
		cx: CENTER_RST, cy: CENTER_RST, isx: SCALE_RST, isy: SCALE_RST,
		w: EXTENT_RST, h: EXTENT_RST};

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index   = REG_COS_ANGLE;
	logic [CFG_DW-1:0]   cfg_data    = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                mode        = MODE_LOAD;
	logic signed [12:0]  pos_x       = '0;
	logic signed [12:0]  pos_y       = '0;
	logic [31:0]         pixel_color = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [31:0]         sample_color;
	logic                sample_visible;

	int fail_count, in_flight, checked_count, sample_count, lit_count;
	int cycles = 0;
	int settings_done = 0;
	bit steady = 1'b0;

	rotate_scale_pixel_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pixel_color(pixel_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_color(sample_color), .sample_visible(sample_visible)
	);

	rss_sampler_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pixel_color(pixel_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_color(sample_color), .sample_visible(sample_visible),
		.fail_count(fail_count), .in_flight(in_flight),
		.checked_count(checked_count), .sample_count(sample_count),
		.lit_count(lit_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= steady || ($urandom_range(99) >= 27);
	end

	function automatic logic [31:0] rand_color();
		case ($urandom_range(9))
			0, 1:    return {8'h00, 24'($urandom)};
			2:       return {8'hFF, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [12:0] fit13(int v);
		if (v > 4095)
			return 13'sd4095;
		if (v < -4096)
			return -13'sd4096;
		return 13'(v);
	endfunction

	// destination half size around the center that still maps onto the source
	function automatic int reach(setting_t s);
		int ax, ay, m, e, r;
		ax = (s.isx < 0) ? -int'(s.isx) : int'(s.isx);
		ay = (s.isy < 0) ? -int'(s.isy) : int'(s.isy);
		m  = (ax == 0) ? ay : ((ay == 0 || ax < ay) ? ax : ay);
		if (m == 0)
			return 64;
		e = (int'(s.w) > int'(s.h)) ? int'(s.w) : int'(s.h);
		r = e * 256 / m + 4;
		return (r > 4095) ? 4095 : r;
	endfunction

	// extents stay inside the filled corner block unless reads still hit only filled entries
	function automatic setting_t pick_setting(int ph);
		setting_t s;
		int c, sn;
		s = BOOT_SETTING;
		case (ph)
			0: begin
				s.cx = 18'sd1024;
				s.cy = 18'sd1024;
				s.w  = 8'd16;
				s.h  = 8'd16;
			end
			1: begin
				s.cos_a = -16'sd16384;
				s.cx    = 18'sd131071;
				s.cy    = -18'sd131072;
				s.isx   = 17'sd65535;
				s.isy   = -17'sd65535;
				s.w     = 8'd16;
				s.h     = 8'd16;
			end
			2: begin
				s.cos_a = 16'sd0;
				s.sin_a = -16'sd16384;
				s.isx   = 17'sd128;
				s.isy   = 17'sd512;
				s.w     = 8'd16;
				s.h     = 8'd11;
			end
			3: begin
				s.cos_a = 16'sd11585;
				s.sin_a = 16'sd11585;
				s.cx    = 18'sd500;
				s.cy    = -18'sd300;
				s.isx   = 17'sd0;
				s.isy   = 17'sd0;
				s.w     = 8'd16;
				s.h     = 8'd31;
			end
			4: begin
				// raw bit patterns, extents past the store on one axis and empty on the other
				s.cos_a = 16'($urandom);
				s.sin_a = 16'($urandom);
				s.cx    = 18'($urandom_range(4095)) - 18'sd2048;
				s.cy    = 18'($urandom_range(4095)) - 18'sd2048;
				s.isx   = 17'($urandom);
				s.isy   = 17'($urandom);
				s.w     = 8'hFF;
				s.h     = 8'h00;
			end
			5: begin
				s.cos_a = 16'sd16384;
				s.sin_a = 16'sd16384;
				s.cx    = -18'sd131072;
				s.cy    = 18'sd131071;
				s.isx   = -17'sd65535;
				s.isy   = 17'sd1;
				s.w     = 8'd1;
				s.h     = 8'd16;
			end
			6: begin
				// width past the store: x indices straddle the last store column
				s.isx = 17'sd1;
				s.isy = 17'sd256;
				s.w   = 8'hFF;
				s.h   = 8'd16;
			end
			default: begin
				c  = int'($urandom_range(32768)) - 16384;
				sn = int'($sqrt(268435456.0 - real'(c) * real'(c)));
				s.cos_a = 16'(c);
				s.sin_a = $urandom_range(1) ? -16'(sn) : 16'(sn);
				s.cx    = 18'(int'($urandom_range(6000)) - 1000);
				s.cy    = 18'(int'($urandom_range(6000)) - 1000);
				s.isx   = 17'($urandom_range(1024, 64));
				s.isy   = 17'($urandom_range(1024, 64));
				if ($urandom_range(1))
					s.isx = -s.isx;
				if ($urandom_range(1))
					s.isy = -s.isy;
				s.w = 8'($urandom_range(FILL_DIM, 1));
				s.h = 8'($urandom_range(FILL_DIM, 1));
			end
		endcase
		return s;
	endfunction

	// entered and left just after a falling edge
	task automatic send_item(logic m, logic signed [12:0] x, logic signed [12:0] y,
			logic [31:0] c);
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode        <= m;
		pos_x       <= x;
		pos_y       <= y;
		pixel_color <= c;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (in_flight != 0)
			@(negedge clk);
	endtask

	task automatic put_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(setting_t s);
		settle();
		put_reg(REG_COS_ANGLE, 18'(s.cos_a));
		put_reg(REG_SIN_ANGLE, 18'(s.sin_a));
		put_reg(REG_DEST_CENTER_X, 18'(s.cx));
		put_reg(REG_DEST_CENTER_Y, 18'(s.cy));
		put_reg(REG_INV_SCALE_X, 18'(s.isx));
		put_reg(REG_INV_SCALE_Y, 18'(s.isy));
		put_reg(REG_SOURCE_WIDTH, 18'(s.w));
		put_reg(REG_SOURCE_HEIGHT, 18'(s.h));
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	task automatic random_item(setting_t s);
		int r, sp;
		r = $urandom_range(99);
		if (r < 20) begin
			if ($urandom_range(9) < 8)
				send_item(MODE_LOAD, 13'($urandom_range(SRC_DIM - 1)),
					13'($urandom_range(SRC_DIM - 1)), rand_color());
			else
				send_item(MODE_LOAD, 13'($urandom), 13'($urandom), rand_color());
		end else if (r < 30) begin
			send_item(MODE_SAMPLE, 13'($urandom), 13'($urandom), $urandom);
		end else begin
			// aim around the destination center so most samples land on the source
			sp = reach(s);
			send_item(MODE_SAMPLE,
				fit13((int'(s.cx) >>> FRAC_BITS_DEF) + int'($urandom_range(2 * sp)) - sp),
				fit13((int'(s.cy) >>> FRAC_BITS_DEF) + int'($urandom_range(2 * sp)) - sp),
				$urandom);
		end
	endtask

	// x maps onto columns 126 to 128, y onto rows 0 to 15
	task automatic clamp_item();
		send_item(MODE_SAMPLE, 13'(int'($urandom_range(760)) - 380),
			13'(int'($urandom_range(FILL_DIM - 1)) - FILL_DIM / 2), $urandom);
	endtask

	initial begin
		setting_t s;
		int ph, k, xi, yi;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity mapping on a one pixel source: (-1,-1) hits the pixel, (0,0) sits on the far edge
		send_item(MODE_LOAD, 13'sd0, 13'sd0, 32'hFFFF_FFFF);
		send_item(MODE_LOAD, -13'sd4096, -13'sd4096, 32'h0000_0000);
		send_item(MODE_LOAD, 13'sd4095, 13'sd4095, 32'hA5A5_A5A5);
		send_item(MODE_LOAD, 13'sd128, 13'sd0, 32'h5A5A_5A5A);
		send_item(MODE_LOAD, 13'sd0, 13'sd128, 32'h1234_5678);
		send_item(MODE_LOAD, 13'sd127, 13'sd127, 32'h8012_3456);
		send_item(MODE_SAMPLE, -13'sd1, -13'sd1, 32'h0000_0000);
		send_item(MODE_SAMPLE, 13'sd0, 13'sd0, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, -13'sd1, 13'sd0, 32'h0000_0000);
		send_item(MODE_SAMPLE, 13'sd4095, 13'sd4095, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, -13'sd4096, -13'sd4096, 32'h0000_0000);
		send_item(MODE_LOAD, 13'sd0, 13'sd0, 32'h00FF_FFFF);
		send_item(MODE_SAMPLE, -13'sd1, -13'sd1, $urandom);
		send_item(MODE_LOAD, 13'sd0, 13'sd0, 32'h0100_0000);
		send_item(MODE_SAMPLE, -13'sd1, -13'sd1, $urandom);

		// zero inverse scale pins both axes to the middle index
		s = BOOT_SETTING;
		s.isx = 17'sd0;
		s.isy = 17'sd0;
		configure(s);
		send_item(MODE_SAMPLE, 13'sd4095, -13'sd4096, $urandom);

		// flip both axes
		s.isx = -17'sd256;
		s.isy = -17'sd256;
		configure(s);
		send_item(MODE_SAMPLE, 13'sd0, 13'sd0, $urandom);
		send_item(MODE_SAMPLE, -13'sd1, -13'sd1, $urandom);

		// quarter turn with the flip kept
		s.cos_a = 16'sd0;
		s.sin_a = 16'sd16384;
		configure(s);
		send_item(MODE_SAMPLE, -13'sd1, 13'sd0, $urandom);
		send_item(MODE_SAMPLE, 13'sd0, -13'sd1, $urandom);

		// fill the corner block and the last two columns beside it, the only
		// entries any later sample can read
		for (yi = 0; yi < FILL_DIM; yi++)
			for (xi = 0; xi < FILL_DIM; xi++)
				send_item(MODE_LOAD, 13'(xi), 13'(yi), rand_color());
		for (yi = 0; yi < FILL_DIM; yi++) begin
			send_item(MODE_LOAD, 13'(SRC_DIM - 2), 13'(yi), rand_color());
			send_item(MODE_LOAD, 13'(SRC_DIM - 1), 13'(yi), rand_color());
		end

		for (ph = 0; ph < PHASES; ph++) begin
			s = pick_setting(ph);
			steady = (ph == 2 || ph == 8);
			configure(s);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == CLAMP_PHASE)
					clamp_item();
				else
					random_item(s);
			end
		end

		settle();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d results compared over %0d register settings,",
			checked_count, settings_done);
		$display("summary: %0d samples, %0d of them drew an opaque source pixel",
			sample_count, lit_count);
		if (fail_count == 0 && in_flight == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
